// ----- rtl/lpip_pkg.sv -----
package lpip_pkg;

    // Default number of fraction bits of the fixed-point coordinates and coefficients.
    localparam int FRAC_BITS_DEF = 16;

    // Number of quotient bits that the pixel divider resolves.
    localparam int QUOT_BITS = 12;

    // Widest image side in pixels.
    localparam int MAX_DIM = 4096;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int DIM_W      = 13;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_C01 = 3'd0,
        REG_ROW0_C23 = 3'd1,
        REG_ROW1_C01 = 3'd2,
        REG_ROW1_C23 = 3'd3,
        REG_ROW2_C01 = 3'd4,
        REG_ROW2_C23 = 3'd5,
        REG_IMG_W    = 3'd6,
        REG_IMG_H    = 3'd7
    } cfg_reg_t;

endpackage

// ----- rtl/lidar_point_image_projection.sv -----
// Throughput: one point per cycle; the pipeline stops as a whole only while a result waits.
// The two pixel dividers resolve one quotient bit per stage and set the depth of the pipe.
// Reset (rst_n, asynchronous, active low) empties the pipeline, clears the matrix to zero
// and sets the image to 640 by 480 pixels.
module lidar_point_image_projection
    import lpip_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  point_valid,
    output logic                  point_ready,
    input  logic signed [31:0]    point_x,
    input  logic signed [31:0]    point_y,
    input  logic signed [31:0]    point_z,
    output logic                  pixel_valid,
    input  logic                  pixel_ready,
    output logic [11:0]           pixel_col,
    output logic [11:0]           pixel_row,
    output logic [7:0]            color_red,
    output logic [7:0]            color_green,
    output logic [7:0]            color_blue
);

    // A product floored by FRAC_BITS keeps PW bits; three of them plus the translation
    // term need VW bits. The colour arithmetic works in CW bits.
    localparam int PW  = 64 - FRAC_BITS;
    localparam int VW  = PW + 2;
    localparam int CW  = VW + 8;
    localparam int DSH = FRAC_BITS + 3;
    localparam logic signed [CW-1:0] HALF_DEPTH = CW'(40) << FRAC_BITS;
    localparam logic signed [CW-1:0] FULL_DEPTH = CW'(80) << FRAC_BITS;
    localparam logic signed [CW-1:0] ROUND_ADD  = (CW'(1) << DSH) - CW'(1);

    typedef struct packed {
        logic       valid;
        logic       agree_u;
        logic       agree_v;
        logic       wzero;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } side_t;

    // Configuration registers. Writes must arrive only while the pipe is empty; the block itself does not enforce it.
    logic [CFG_DATA_W-1:0] proj_reg [0:5];
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                proj_reg[i] <= '0;
            end
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ROW0_C01: proj_reg[0] <= cfg_data;
                REG_ROW0_C23: proj_reg[1] <= cfg_data;
                REG_ROW1_C01: proj_reg[2] <= cfg_data;
                REG_ROW1_C23: proj_reg[3] <= cfg_data;
                REG_ROW2_C01: proj_reg[4] <= cfg_data;
                REG_ROW2_C23: proj_reg[5] <= cfg_data;
                REG_IMG_W:    width_reg   <= cfg_data[DIM_W-1:0];
                REG_IMG_H:    height_reg  <= cfg_data[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    // Sides larger than the widest image behave as the widest image.
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;

    assign width_eff  = (width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_reg;
    assign height_eff = (height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_reg;

    // The whole pipe moves together unless a finished result is still waiting.
    logic en;
    logic out_valid_reg;

    assign en          = !(out_valid_reg && !pixel_ready);
    assign point_ready = en;

    // Stage 1: nine coefficient by coordinate products.
    logic signed [63:0] prod_reg [0:2][0:2];
    logic               s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[r][0] <= $signed(proj_reg[2*r][31:0])   * point_x;
                prod_reg[r][1] <= $signed(proj_reg[2*r][63:32])  * point_y;
                prod_reg[r][2] <= $signed(proj_reg[2*r+1][31:0]) * point_z;
            end
        end
    end

    // Stage 2: floor each product by FRAC_BITS (drop low bits) and add the translation.
    logic signed [VW-1:0] sum_reg [0:2];
    logic                 s2_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= VW'(signed'(prod_reg[r][0][63:FRAC_BITS]))
                            + VW'(signed'(prod_reg[r][1][63:FRAC_BITS]))
                            + VW'(signed'(prod_reg[r][2][63:FRAC_BITS]))
                            + VW'(signed'(proj_reg[2*r+1][63:32]));
            end
        end
    end

    // Colour helpers: a division by 8 * 2^FRAC_BITS truncated toward zero, then saturation.
    function automatic logic [7:0] scale_sat(input logic signed [CW-1:0] p);
        logic signed [CW-1:0] t;
        begin
            t = (p[CW-1] ? (p + ROUND_ADD) : p) >>> DSH;
            if (t < 0)
            begin
                scale_sat = 8'd0;
            end
            else if (t > CW'(255))
            begin
                scale_sat = 8'd255;
            end
            else
            begin
                scale_sat = t[7:0];
            end
        end
    endfunction

    // Stage 3: magnitudes and signs for the dividers, depth colour.
    logic [VW-1:0]        absu_reg;
    logic [VW-1:0]        absv_reg;
    logic [VW-1:0]        absw_reg;
    side_t                s3_reg;
    side_t                s3_next;
    logic signed [CW-1:0] wx;

    always_comb
    begin
        wx            = CW'(sum_reg[2]);
        s3_next       = '0;
        s3_next.valid = s2_valid_reg;
        s3_next.agree_u = (sum_reg[0][VW-1] == sum_reg[2][VW-1]);
        s3_next.agree_v = (sum_reg[1][VW-1] == sum_reg[2][VW-1]);
        s3_next.wzero   = (sum_reg[2] == '0);
        if (wx <= HALF_DEPTH)
        begin
            s3_next.green = scale_sat((HALF_DEPTH - wx) * CW'(51));
            s3_next.red   = scale_sat(wx * CW'(51));
            s3_next.blue  = 8'd0;
        end
        else if (wx <= FULL_DEPTH)
        begin
            s3_next.green = 8'd0;
            s3_next.red   = scale_sat((FULL_DEPTH - wx) * CW'(51));
            s3_next.blue  = scale_sat((wx - HALF_DEPTH) * CW'(51));
        end
        else
        begin
            s3_next.red   = 8'd255;
            s3_next.green = 8'd0;
            s3_next.blue  = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            absu_reg <= sum_reg[0][VW-1] ? VW'(-sum_reg[0]) : VW'(sum_reg[0]);
            absv_reg <= sum_reg[1][VW-1] ? VW'(-sum_reg[1]) : VW'(sum_reg[1]);
            absw_reg <= sum_reg[2][VW-1] ? VW'(-sum_reg[2]) : VW'(sum_reg[2]);
        end
    end

    // Side data travels beside the dividers, one register per divider stage.
    side_t side_reg [0:QUOT_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_reg       <= '0;
            for (int i = 0; i <= QUOT_BITS; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            s1_valid_reg <= point_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_reg       <= s3_next;
            side_reg[0]  <= s3_reg;
            for (int i = 1; i <= QUOT_BITS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Column and row magnitudes: |u| / |w| and |v| / |w|.
    logic [QUOT_BITS-1:0] qu;
    logic [QUOT_BITS-1:0] qv;
    logic                 ovf_u;
    logic                 ovf_v;

    lpip_qdiv #(.VW(VW), .QW(QUOT_BITS)) u_div_col
    (
        .clk   (clk),
        .en    (en),
        .num   (absu_reg),
        .den   (absw_reg),
        .quot  (qu),
        .ovf   (ovf_u)
    );

    lpip_qdiv #(.VW(VW), .QW(QUOT_BITS)) u_div_row
    (
        .clk   (clk),
        .en    (en),
        .num   (absv_reg),
        .den   (absw_reg),
        .quot  (qv),
        .ovf   (ovf_v)
    );

    // A quotient of zero is a valid pixel whatever the signs; otherwise the signs must agree
    // so that the truncated quotient is positive.
    side_t side_last;
    logic  col_ok;
    logic  row_ok;
    logic  hit;

    assign side_last = side_reg[QUOT_BITS];
    assign col_ok = !ovf_u && ((qu == '0) || side_last.agree_u)
                    && ({1'b0, qu} < width_eff);
    assign row_ok = !ovf_v && ((qv == '0) || side_last.agree_v)
                    && ({1'b0, qv} < height_eff);
    assign hit    = side_last.valid && !side_last.wzero && col_ok && row_ok;

    // Output register.
    logic [11:0] col_reg;
    logic [11:0] row_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg   <= 12'(qu);
            row_reg   <= 12'(qv);
            red_reg   <= side_last.red;
            green_reg <= side_last.green;
            blue_reg  <= side_last.blue;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_col   = col_reg;
    assign pixel_row   = row_reg;
    assign color_red   = red_reg;
    assign color_green = green_reg;
    assign color_blue  = blue_reg;

endmodule

// ----- rtl/lpip_qdiv.sv -----
module lpip_qdiv
    import lpip_pkg::*;
#(
    parameter int VW = 50,
    parameter int QW = QUOT_BITS
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] num,
    input  logic [VW-1:0] den,
    output logic [QW-1:0] quot,
    output logic          ovf
);

    // The first stage flags quotients of 2^QW or more; each later stage resolves one bit.
    logic [VW-1:0] rem_reg [0:QW];
    logic [VW-1:0] den_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic          ovf_reg [0:QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= {{QW{1'b0}}, num} >= {den, {QW{1'b0}}};
        end
    end

    for (genvar i = 1; i <= QW; i++)
    begin : g_stage
        localparam int B = QW - i;
        logic [VW+QW:0] trial;
        logic [VW+QW:0] shifted;

        always_comb
        begin
            shifted = {{(QW+1){1'b0}}, den_reg[i-1]} << B;
            trial   = {{(QW+1){1'b0}}, rem_reg[i-1]} - shifted;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
                if (!trial[VW+QW])
                begin
                    rem_reg[i]  <= trial[VW-1:0];
                    q_reg[i]    <= q_reg[i-1] | (QW'(1) << B);
                end
                else
                begin
                    rem_reg[i]  <= rem_reg[i-1];
                    q_reg[i]    <= q_reg[i-1];
                end
            end
        end
    end

    assign quot = q_reg[QW];
    assign ovf  = ovf_reg[QW];

endmodule
